>>> sv/isle_pkg.sv
// Shared types and constants for the indexed sorted list engine.
// No dependencies; every other file in sv/ imports this package.
package isle_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int POS_W      = 7;
    localparam int MODE_W     = 3;
    localparam int VAL_W      = 32;
    localparam int STAT_W     = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SORTED     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REMOVE_VAL = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd6;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  position;
    } req_t;

    typedef struct packed {
        logic [VAL_W-1:0]  value_out;
        logic [POS_W-1:0]  position_out;
        logic              found;
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  count_out;
    } rsp_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                  ins;
        logic                  rem;
        logic [POS_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] value;
        logic [POS_W-1:0]      count;
    } cell_ctl_t;

endpackage

>>> sv/indexed_sorted_list_engine_core.sv
// Top level of the indexed sorted list engine: controller plus cell row.
// Depends on isle_pkg, isle_cell and isle_pick.
//
//  channel | direction | handshake          | beat type
//  req     | in        | req_valid/req_stall| req_t (mode, value, position)
//  rsp     | out       | rsp_valid/rsp_stall| rsp_t (value_out .. count_out)
//
// Each request is handled in S_EVAL, which compares across all cells and picks
// a position, then in S_APPLY, which shifts the cell row and loads the result register.
// The next request is taken in the same cycle that the previous one commits.
// Reset empties the list; entry contents are left as they are.
// A stalled result holds the commit cycle, and with it the request side.
module indexed_sorted_list_engine_core
    import isle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]            state_reg, state_next;
    req_t                  req_reg;
    logic [POS_W-1:0]      count_reg, count_next;
    rsp_t                  res_reg, res_next;
    logic                  ins_reg, ins_next;
    logic                  rem_reg, rem_next;
    logic [POS_W-1:0]      tgt_reg, tgt_next;
    logic [POS_W-1:0]      new_count_reg, new_count_next;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic                  req_take;
    logic                  commit;
    cell_ctl_t             ctl;
    logic [DATA_WIDTH-1:0] entry [CAPACITY];
    logic [CAPACITY-1:0]   lt_vec, eq_vec, flags;
    logic [POS_W-1:0]      pick_index;
    logic                  pick_hit;
    logic [DATA_WIDTH-1:0] rd_value;
    logic                  full;

    assign commit    = (state_reg == S_APPLY) && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = !((state_reg == S_IDLE) || commit);
    assign req_take  = req_valid && !req_stall;

    assign ctl.ins   = commit && ins_reg;
    assign ctl.rem   = commit && rem_reg;
    assign ctl.pos   = tgt_reg;
    assign ctl.value = req_reg.value[DATA_WIDTH-1:0];
    assign ctl.count = count_reg;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_in, right_in;
        if (g == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid
            assign left_in = entry[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign right_in = entry[g];
        end
        else
        begin : g_inner
            assign right_in = entry[g+1];
        end
        isle_cell u_cell (
            .clk   (clk),
            .idx   (POS_W'(g)),
            .ctl   (ctl),
            .left  (left_in),
            .right (right_in),
            .entry (entry[g]),
            .lt    (lt_vec[g]),
            .eq    (eq_vec[g])
        );
    end

    assign flags = (req_reg.mode == MODE_SORTED) ? lt_vec : eq_vec;

    isle_pick u_pick (
        .flags (flags),
        .count (count_reg),
        .index (pick_index),
        .hit   (pick_hit)
    );

    // Select the word at the requested position.
    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (req_reg.position == POS_W'(i))
            begin
                rd_value = rd_value | entry[i];
            end
        end
    end

    assign full = count_reg >= POS_W'(CAPACITY);

    always_comb
    begin
        res_next       = res_reg;
        ins_next       = ins_reg;
        rem_next       = rem_reg;
        tgt_next       = tgt_reg;
        new_count_next = new_count_reg;
        if (state_reg == S_EVAL)
        begin
            res_next       = '0;
            ins_next       = 1'b0;
            rem_next       = 1'b0;
            tgt_next       = req_reg.position;
            new_count_next = count_reg;
            unique case (req_reg.mode) inside
                MODE_INSERT:
                begin
                    res_next.position_out = req_reg.position;
                    if (req_reg.position > count_reg)
                    begin
                        res_next.status = STAT_RANGE;
                    end
                    else if (full)
                    begin
                        res_next.status = STAT_FULL;
                    end
                    else
                    begin
                        ins_next       = 1'b1;
                        new_count_next = count_reg + 1'b1;
                    end
                end
                MODE_SORTED:
                begin
                    res_next.position_out = pick_index;
                    tgt_next              = pick_index;
                    if (full)
                    begin
                        res_next.status = STAT_FULL;
                    end
                    else
                    begin
                        ins_next       = 1'b1;
                        new_count_next = count_reg + 1'b1;
                    end
                end
                MODE_REMOVE, MODE_READ:
                begin
                    res_next.position_out = req_reg.position;
                    if (req_reg.position >= count_reg)
                    begin
                        res_next.status = STAT_RANGE;
                    end
                    else
                    begin
                        res_next.value_out = VAL_W'(rd_value);
                        if (req_reg.mode == MODE_REMOVE)
                        begin
                            rem_next       = 1'b1;
                            new_count_next = count_reg - 1'b1;
                        end
                    end
                end
                MODE_FIND:
                begin
                    res_next.position_out = pick_index;
                    res_next.found        = pick_hit;
                end
                MODE_REMOVE_VAL:
                begin
                    res_next.position_out = pick_index;
                    tgt_next              = pick_index;
                    if (pick_hit)
                    begin
                        res_next.found     = 1'b1;
                        res_next.value_out = VAL_W'(req_reg.value[DATA_WIDTH-1:0]);
                        rem_next           = 1'b1;
                        new_count_next     = count_reg - 1'b1;
                    end
                    else
                    begin
                        res_next.status = STAT_RANGE;
                    end
                end
                MODE_CLEAR:
                begin
                    new_count_next = '0;
                end
                default:
                begin
                    res_next.status = STAT_RANGE;
                end
            endcase
            res_next.count_out = new_count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (commit)
                begin
                    count_next = new_count_reg;
                    state_next = req_take ? S_EVAL : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req;
        end
        if (commit)
        begin
            rsp_reg <= res_reg;
        end
        res_reg       <= res_next;
        ins_reg       <= ins_next;
        rem_reg       <= rem_next;
        tgt_reg       <= tgt_next;
        new_count_reg <= new_count_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= POS_W'(CAPACITY))
        else $error("entry count above capacity");

    a_take_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> state_reg == S_EVAL)
        else $error("accepted beat did not start evaluation");

    a_count_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("entry count moved outside a commit");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the list by one");
`endif

endmodule

>>> sv/isle_cell.sv
// One list slot: holds an entry, compares it with the broadcast word and
// shifts toward either neighbor on insert or remove. Depends on isle_pkg.
module isle_cell
    import isle_pkg::*;
(
    input  logic                  clk,
    input  logic [POS_W-1:0]      idx,
    input  cell_ctl_t             ctl,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    output logic [DATA_WIDTH-1:0] entry,
    output logic                  lt,
    output logic                  eq
);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  active;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins && idx == ctl.pos)
        begin
            entry_next = ctl.value;
        end
        else if (ctl.ins && idx > ctl.pos)
        begin
            entry_next = left;
        end
        else if (ctl.rem && idx >= ctl.pos)
        begin
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign active = idx < ctl.count;
    assign lt     = active && (ctl.value < entry_reg);
    assign eq     = active && (ctl.value == entry_reg);
    assign entry  = entry_reg;

endmodule

>>> sv/isle_pick.sv
// Priority pick: lowest flagged cell index, or the entry count if none.
// Depends on isle_pkg.
module isle_pick
    import isle_pkg::*;
(
    input  logic [CAPACITY-1:0] flags,
    input  logic [POS_W-1:0]    count,
    output logic [POS_W-1:0]    index,
    output logic                hit
);

    always_comb
    begin
        index = count;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (flags[i])
            begin
                index = POS_W'(i);
            end
        end
    end

    assign hit = |flags;

endmodule
